### rtl/ced_pkg.sv
// Shared constants, types and the divider step for the cell exit distance block.
`default_nettype none
package ced_pkg;

  localparam int POS_INT_BITS = 10;
  localparam int FRAC_BITS    = 14;
  localparam int POS_W        = POS_INT_BITS + FRAC_BITS;
  localparam int DIR_W        = 16;
  localparam int THR_W        = 15;
  localparam int DIST_W       = 16 + FRAC_BITS;
  localparam int OFS_W        = FRAC_BITS + 1;
  localparam int NUM_W        = OFS_W + FRAC_BITS;
  localparam int REM_W        = DIR_W + 1;
  localparam int DIV_STEPS    = NUM_W;
  localparam int IN_W         = 3 * POS_W + 3 * DIR_W;
  localparam int IN_BYTES_W   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_BYTES_W  = ((DIST_W + 7) / 8) * 8;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  // One restoring division step: partial remainder, quotient bit.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             qbit;
  } div_step_t;

  function automatic div_step_t div_step(input logic [REM_W-1:0] rem,
                                         input logic             nbit,
                                         input logic [DIR_W-1:0] den);
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] dx;
    div_step_t        r;
    sh = {rem[REM_W-2:0], nbit};
    dx = {1'b0, den};
    if (sh >= dx) begin
      r.rem  = sh - dx;
      r.qbit = 1'b1;
    end else begin
      r.rem  = sh;
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/ced_prep.sv
// Front stage of one axis: face offset, component magnitude and parallel test.
`default_nettype none
module ced_prep import ced_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [POS_W-1:0] pos_i,
  input  wire logic [DIR_W-1:0] dir_i,
  input  wire logic [THR_W-1:0] thr_i,
  output logic      [NUM_W-1:0] num_o,
  output logic      [DIR_W-1:0] den_o,
  output logic                  act_o
);

  logic [FRAC_BITS-1:0] frac;
  logic                 neg;
  logic [DIR_W-1:0]     mag;
  logic [OFS_W-1:0]     ofs;
  logic [NUM_W-1:0]     num_d, num_q;
  logic [DIR_W-1:0]     den_q;
  logic                 act_d, act_q;

  // Offset to the face ahead; a zero offset counts as one whole cell
  always_comb begin
    frac = pos_i[FRAC_BITS-1:0];
    neg  = dir_i[DIR_W-1];
    mag  = neg ? (~dir_i + DIR_W'(1)) : dir_i;
    if (neg) ofs = {1'b0, frac};
    else     ofs = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    if (ofs == '0) ofs = {1'b1, {FRAC_BITS{1'b0}}};
    num_d = {ofs, {FRAC_BITS{1'b0}}};
    act_d = mag > {{(DIR_W-THR_W){1'b0}}, thr_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= mag;
      act_q <= act_d;
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;
  assign act_o = act_q;

endmodule
`default_nettype wire

### rtl/ced_div_lane.sv
// Pipelined restoring divider for one axis, one quotient bit per stage.
`default_nettype none
module ced_div_lane import ced_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DIR_W-1:0] den_i,
  input  wire logic             act_i,
  output logic      [NUM_W-1:0] quo_o,
  output logic                  act_o
);

  logic [NUM_W-1:0] num_q [DIV_STEPS];
  logic [NUM_W-1:0] quo_q [DIV_STEPS];
  logic [REM_W-1:0] rem_q [DIV_STEPS];
  logic [DIR_W-1:0] den_q [DIV_STEPS];
  logic             act_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [NUM_W-1:0] num_in, quo_in;
    logic [REM_W-1:0] rem_in;
    logic [DIR_W-1:0] den_in;
    logic             act_in;
    div_step_t        st;

    // Select the previous stage or the lane input
    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
      assign act_in = act_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign act_in = act_q[k-1];
    end

    assign st = div_step(rem_in, num_in[NUM_W-1], den_in);

    // Advance one quotient bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= {num_in[NUM_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[NUM_W-2:0], st.qbit};
        rem_q[k] <= st.rem;
        den_q[k] <= den_in;
        act_q[k] <= act_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];
  assign act_o = act_q[DIV_STEPS-1];

endmodule
`default_nettype wire

### rtl/cell_exit_distance.sv
// Top level: distance along a flow direction to the nearest face of the grid cell.
//
// channel   direction  contents
// s_axis    in         tdata: pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
// m_axis    out        tdata: exit_distance; tuser: no_crossing
// cfg       in         cfg_data_i: parallel_threshold
//
// One transaction per cycle enters while m_axis does not stall; the pipeline is one prep stage,
// 29 divider stages (one quotient bit each) and the min/output register.
// Reset clears the valid bits and sets the threshold to 16.
// When m_axis stalls, the whole pipeline holds; s_axis_tready follows it.
`default_nettype none
module cell_exit_distance import ced_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z from the lowest bit
  input  wire logic [IN_BYTES_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // exit_distance, then zero fill
  output logic      [OUT_BYTES_W-1:0] m_axis_tdata,
  // no_crossing
  output logic                        m_axis_tuser,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [THR_W-1:0]       cfg_data_i
);

  logic             adv;
  logic [THR_W-1:0] thr_q;
  logic [DIV_STEPS:0] vld_q;
  logic             out_vld_q;
  logic [DIST_W-1:0] dist_d, dist_q;
  logic             nocross_d, nocross_q;
  logic [NUM_W-1:0] num [3];
  logic [DIR_W-1:0] den [3];
  logic             pact [3];
  logic [NUM_W-1:0] quo [3];
  logic             act [3];

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  // Hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    ced_prep u_prep (
      .clk_i (clk_i),
      .en_i  (adv),
      .pos_i (s_axis_tdata[a*POS_W +: POS_W]),
      .dir_i (s_axis_tdata[3*POS_W + a*DIR_W +: DIR_W]),
      .thr_i (thr_q),
      .num_o (num[a]),
      .den_o (den[a]),
      .act_o (pact[a])
    );
    ced_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num[a]),
      .den_i (den[a]),
      .act_i (pact[a]),
      .quo_o (quo[a]),
      .act_o (act[a])
    );
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[DIV_STEPS-1:0], s_axis_tvalid};
      out_vld_q <= vld_q[DIV_STEPS];
    end
  end

  // Take the minimum over active axes
  always_comb begin
    dist_d    = '1;
    nocross_d = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (act[a]) begin
        if (nocross_d || {1'b0, quo[a]} < dist_d) dist_d = {1'b0, quo[a]};
        nocross_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q    <= dist_d;
      nocross_q <= nocross_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_BYTES_W-DIST_W){1'b0}}, dist_q};
  assign m_axis_tuser  = nocross_q;

endmodule
`default_nettype wire

### rtl/ced_checker.sv
// Port-level checker for the cell exit distance block, bound to the top level.
`default_nettype none
module ced_checker import ced_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_BYTES_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser
);

  // Output holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction dropped or changed under stall");

  // Input side stalls exactly when a result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // No crossing implies maximal distance
  a_nocross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[DIST_W-1:0] == '1)
    else $error("no crossing without maximal distance");

  // Quotient never reaches the top distance bit unless no crossing
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_BYTES_W-1:NUM_W] == '0)
    else $error("distance out of range");

endmodule

bind cell_exit_distance ced_checker u_ced_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### dv/testbench.sv
// Testbench for cell_exit_distance: random and directed stream checks against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import ced_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] exit_dist;
    logic              none;
  } exit_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z from the lowest bit
  logic [IN_BYTES_W-1:0]  s_axis_tdata = '0;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // exit_distance, then zero fill
  wire  [OUT_BYTES_W-1:0] m_axis_tdata;
  // no_crossing
  wire                    m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  wire                    cfg_ready_o;
  logic [THR_W-1:0]       cfg_data_i = '0;

  logic [THR_W-1:0] threshold = THR_RESET;
  exit_t            exits_pending[$];
  int               src_idle_pct = 0;
  int               snk_idle_pct = 0;
  int               quiet_cycles = 0;
  bit               failed = 1'b0;

  localparam int WATCHDOG = 20000;

  cell_exit_distance uut (.*);

  always #1 clk_i = ~clk_i;

  // Per-axis distance; returns 0 when the axis is parallel.
  function automatic bit axis_dist(input logic [POS_W-1:0] p, input logic [DIR_W-1:0] d,
                                   output logic [63:0] q);
    logic [63:0] one, frac, mag, ofs;
    one  = 64'd1 << FRAC_BITS;
    frac = p & (one - 1);
    mag  = d[DIR_W-1] ? (64'd65536 - d) : d;
    if (mag <= threshold) return 1'b0;
    ofs = d[DIR_W-1] ? frac : one - frac;
    if (ofs == 0) ofs = one;
    q = (ofs << FRAC_BITS) / mag;
    if (q > {DIST_W{1'b1}}) q = {DIST_W{1'b1}};
    return 1'b1;
  endfunction

  function automatic exit_t predict_exit(input logic [IN_W-1:0] item);
    exit_t       r;
    logic [63:0] q;
    r.exit_dist = '1;
    r.none = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (axis_dist(item[a*POS_W +: POS_W], item[3*POS_W + a*DIR_W +: DIR_W], q)) begin
        if (r.none || q < r.exit_dist) r.exit_dist = q[DIST_W-1:0];
        r.none = 1'b0;
      end
    end
    return r;
  endfunction

  // Send one transaction; valid stays high afterwards until the next idle or drain.
  task automatic send_item(input logic [POS_W-1:0] px, py, pz,
                           input logic [DIR_W-1:0] dx, dy, dz);
    logic [IN_W-1:0] item;
    item = {dz, dy, dx, pz, py, px};
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= IN_BYTES_W'(item);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exits_pending.push_back(predict_exit(item));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (exits_pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    drain();
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    threshold = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DIR_W-1:0] rand_dir();
    case ($urandom_range(5))
      0: return DIR_W'($urandom_range(40));
      1: return -DIR_W'($urandom_range(40));
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return DIR_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    logic [POS_W-1:0] p;
    p = POS_W'($urandom);
    if ($urandom_range(3) == 0) p[FRAC_BITS-1:0] = '0;
    return p;
  endfunction

  task automatic test_directed();
    // extremes, faces, tiny components and all-parallel
    send_item('0, '0, '0, '0, '0, '0);
    send_item('1, '1, '1, 16'h7fff, 16'h8000, 16'h0001);
    send_item(24'h004000, '0, '0, 16'hc000, '0, '0);
    send_item(24'h004000, '0, '0, 16'h4000, '0, '0);
    send_item(24'h000001, 24'h003fff, '0, 16'h0011, 16'hffef, '0);
    send_item(24'h002000, 24'h002000, 24'h002000, 16'h0010, 16'hfff0, 16'h0011);
    send_item('1, '0, 24'h001234, 16'h8000, 16'h7fff, 16'hffff);
    send_item(24'haaaaaa, 24'h555555, 24'h000000, 16'h5555, 16'haaaa, 16'h8001);
    write_threshold('0);
    send_item(24'h000001, '0, '0, 16'h0001, 16'h0000, 16'h0000);
    send_item('0, '0, '0, 16'hffff, 16'h0000, 16'h0000);
    send_item('0, '0, '0, '0, '0, '0);
    write_threshold('1);
    send_item('0, '0, '0, 16'h8000, 16'h7fff, 16'h8001);
    write_threshold(15'd16384);
    send_item('0, '0, '0, 16'h8000, 16'h4000, 16'hc000);
    send_item(24'h001000, '0, '0, 16'h4001, 16'h4000, 16'hc000);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(rand_pos(), rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir());
    end
  endtask

  // Check each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exits_pending.size() == 0) begin
        $display("%0t: unexpected result dist=%h none=%b", $time,
                 m_axis_tdata[DIST_W-1:0], m_axis_tuser);
        failed = 1'b1;
      end else begin
        exit_t e;
        e = exits_pending.pop_front();
        if (m_axis_tdata !== OUT_BYTES_W'(e.exit_dist) || m_axis_tuser !== e.none) begin
          $display("%0t: mismatch expected dist=%h none=%b actual dist=%h none=%b",
                   $time, e.exit_dist, e.none, m_axis_tdata, m_axis_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // Drive the receiver stall pattern.
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

  // Count cycles with no transaction and give up after too many.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 31;
    snk_idle_pct = 52;
    test_directed();
    write_threshold(15'd16);
    test_random(300);
    src_idle_pct = 52;
    snk_idle_pct = 31;
    write_threshold(15'd300);
    test_random(300);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_threshold(15'(32));
    test_random(300);
    drain();
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

### cell_exit_distance.f
rtl/ced_pkg.sv
rtl/ced_prep.sv
rtl/ced_div_lane.sv
rtl/cell_exit_distance.sv
rtl/ced_checker.sv
dv/testbench.sv
